[rtl/pme_pkg.sv]
// ----------------------------------------------------------------------------
// pme_pkg
// Shared widths, register indexes, shape codes, result kinds and the
// restoring division step for the piecewise membership evaluator.
// ----------------------------------------------------------------------------
package pme_pkg;

    // field and datapath widths
    localparam int SAMPLE_W        = 16;
    localparam int FRAC_W          = 15;
    localparam int DEG_W           = FRAC_W + 1;
    localparam int DEN_W           = SAMPLE_W;
    localparam int REM_W           = DEN_W + 1;
    localparam int QUO_W           = FRAC_W + 1;
    localparam int PROD_W          = 2 * QUO_W;
    localparam int SQ_W            = QUO_W + 1;
    localparam int MODE_W          = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = SAMPLE_W;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 24;

    // divider pipeline shape: one quotient bit per step
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

    // 1.0 in the degree format
    localparam logic [DEG_W-1:0] ONE_Q = DEG_W'(1) << FRAC_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_C    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_D    = 3'd4;

    // shape codes
    localparam logic [MODE_W-1:0] MODE_RISING    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FALLING   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRAPEZOID = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SCURVE    = 3'd4;

    // how the final degree is formed from the quotient
    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_ERR,
        KIND_RAMP,
        KIND_SRISE,
        KIND_SFALL
    } kind_t;

    // signed difference hi - lo, known to be non-negative where it is used
    function automatic logic [DEN_W-1:0] diff_u(input logic signed [SAMPLE_W-1:0] hi,
                                                 input logic signed [SAMPLE_W-1:0] lo);
        logic signed [SAMPLE_W:0] t;
        t = {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};
        return t[DEN_W-1:0];
    endfunction

    // one restoring step: optional doubling, compare, subtract
    // result is {quotient bit, new remainder}
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                                input logic [DEN_W-1:0] den,
                                                input logic             dbl);
        logic [REM_W-1:0] rs;
        logic             ge;
        rs = dbl ? {r[REM_W-2:0], 1'b0} : r;
        ge = (rs >= {1'b0, den});
        return {ge, ge ? (rs - {1'b0, den}) : rs};
    endfunction

endpackage

[rtl/pme_front.sv]
// ----------------------------------------------------------------------------
// pme_front
// First pipeline stage: compares the sample with the breakpoints, checks
// their ordering for the selected shape and picks the ramp operands.
// ----------------------------------------------------------------------------
module pme_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pme_pkg::SAMPLE_W-1:0]   sample,
    input  logic [pme_pkg::MODE_W-1:0]            shape_mode,
    input  logic signed [pme_pkg::SAMPLE_W-1:0]   point_a,
    input  logic signed [pme_pkg::SAMPLE_W-1:0]   point_b,
    input  logic signed [pme_pkg::SAMPLE_W-1:0]   point_c,
    input  logic signed [pme_pkg::SAMPLE_W-1:0]   point_d,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pme_pkg::kind_t                        out_kind,
    output logic [pme_pkg::DEN_W-1:0]             out_num,
    output logic [pme_pkg::DEN_W-1:0]             out_den
);
    import pme_pkg::*;

    logic              valid_reg;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [DEN_W-1:0]  num_reg;
    logic [DEN_W-1:0]  num_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  den_next;
    logic              lt_a;
    logic              lt_b;
    logic              lt_c;
    logic              lt_d;
    logic              ab_ok;
    logic              bc_ok;
    logic              cd_ok;

    // comparisons for the shapes; lt_d and cd_ok serve only the trapezoid
    assign lt_a  = (sample < point_a);
    assign lt_b  = (sample < point_b);
    assign lt_c  = (sample < point_c);
    assign lt_d  = (sample < point_d);
    assign ab_ok = (point_a < point_b);
    assign bc_ok = (point_b < point_c);
    assign cd_ok = (point_c < point_d);

    // region select per shape
    always_comb
    begin
        kind_next = KIND_ZERO;
        num_next  = diff_u(sample, point_a);
        den_next  = diff_u(point_b, point_a);
        case (shape_mode)
            MODE_RISING:
            begin
                if (!ab_ok)      kind_next = KIND_ERR;
                else if (lt_a)   kind_next = KIND_ZERO;
                else if (!lt_b)  kind_next = KIND_ONE;
                else             kind_next = KIND_RAMP;
            end
            MODE_TRIANGLE:
            begin
                if (!(ab_ok && bc_ok))  kind_next = KIND_ERR;
                else if (lt_a || !lt_c) kind_next = KIND_ZERO;
                else if (lt_b)          kind_next = KIND_RAMP;
                else
                begin
                    kind_next = KIND_RAMP;
                    num_next  = diff_u(point_c, sample);
                    den_next  = diff_u(point_c, point_b);
                end
            end
            MODE_FALLING:
            begin
                num_next = diff_u(point_b, sample);
                if (!ab_ok)      kind_next = KIND_ERR;
                else if (lt_a)   kind_next = KIND_ONE;
                else if (!lt_b)  kind_next = KIND_ZERO;
                else             kind_next = KIND_RAMP;
            end
            MODE_TRAPEZOID:
            begin
                if (!(ab_ok && bc_ok && cd_ok)) kind_next = KIND_ERR;
                else if (lt_a || !lt_d)         kind_next = KIND_ZERO;
                else if (!lt_b && lt_c)         kind_next = KIND_ONE;
                else if (lt_b)                  kind_next = KIND_RAMP;
                else
                begin
                    kind_next = KIND_RAMP;
                    num_next  = diff_u(point_d, sample);
                    den_next  = diff_u(point_d, point_c);
                end
            end
            MODE_SCURVE:
            begin
                den_next = diff_u(point_c, point_a);
                if (!(ab_ok && bc_ok)) kind_next = KIND_ERR;
                else if (lt_a)         kind_next = KIND_ZERO;
                else if (!lt_c)        kind_next = KIND_ONE;
                else if (lt_b)         kind_next = KIND_SRISE;
                else
                begin
                    kind_next = KIND_SFALL;
                    num_next  = diff_u(point_c, sample);
                end
            end
            default:
            begin
                kind_next = KIND_ZERO;
            end
        endcase
    end

    // stage register
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= kind_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

    // a ramp never divides by zero and never exceeds its segment
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_RAMP || out_kind == KIND_SRISE ||
                      out_kind == KIND_SFALL) |-> (out_den != '0) && (out_num <= out_den))
        else $error("pme_front: ramp operands out of range");

    // s-curve never reaches the end of its segment
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_SRISE || out_kind == KIND_SFALL) |-> out_num < out_den)
        else $error("pme_front: s-curve distance reaches segment width");

    // a held beat keeps its place
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind))
        else $error("pme_front: stalled beat lost");

endmodule

[rtl/pme_div.sv]
// ----------------------------------------------------------------------------
// pme_div
// Pipelined restoring divider: quotient = floor(num * 2^FRAC_W / den),
// two quotient bits per stage, result kind carried alongside.
// ----------------------------------------------------------------------------
module pme_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pme_pkg::kind_t                in_kind,
    input  logic [pme_pkg::DEN_W-1:0]     in_num,
    input  logic [pme_pkg::DEN_W-1:0]     in_den,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pme_pkg::kind_t                out_kind,
    output logic [pme_pkg::QUO_W-1:0]     out_quo
);
    import pme_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [REM_W-1:0]      rem_reg  [DIV_STAGES];
    logic [QUO_W-1:0]      quo_reg  [DIV_STAGES];
    logic [DEN_W-1:0]      den_reg  [DIV_STAGES];
    kind_t                 kind_reg [DIV_STAGES];

    logic [DIV_STAGES:0]   st_valid;
    logic [DIV_STAGES:0]   rdy;
    logic [REM_W-1:0]      st_rem   [DIV_STAGES+1];
    logic [QUO_W-1:0]      st_quo   [DIV_STAGES+1];
    logic [DEN_W-1:0]      st_den   [DIV_STAGES+1];
    kind_t                 st_kind  [DIV_STAGES+1];

    // pipeline entry
    assign st_valid[0] = in_valid;
    assign st_rem[0]   = {1'b0, in_num};
    assign st_quo[0]   = '0;
    assign st_den[0]   = in_den;
    assign st_kind[0]  = in_kind;
    assign rdy[DIV_STAGES] = out_ready;
    assign in_ready    = rdy[0];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;
        logic [REM_W:0]   step_res;

        // two dependent subtract steps
        always_comb
        begin
            rem_next = st_rem[s];
            quo_next = st_quo[s];
            step_res = '0;
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                step_res = div_step(rem_next, st_den[s], (s * STEPS_PER_STAGE + k) != 0);
                rem_next = step_res[REM_W-1:0];
                quo_next = {quo_next[QUO_W-2:0], step_res[REM_W]};
            end
        end

        // stage advances when empty or the next one takes its beat
        assign rdy[s] = !valid_reg[s] || rdy[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (rdy[s])
                valid_reg[s] <= st_valid[s];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && st_valid[s])
            begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                den_reg[s]  <= st_den[s];
                kind_reg[s] <= st_kind[s];
            end
        end

        assign st_valid[s+1] = valid_reg[s];
        assign st_rem[s+1]   = rem_reg[s];
        assign st_quo[s+1]   = quo_reg[s];
        assign st_den[s+1]   = den_reg[s];
        assign st_kind[s+1]  = kind_reg[s];
    end

    assign out_valid = st_valid[DIV_STAGES];
    assign out_kind  = st_kind[DIV_STAGES];
    assign out_quo   = st_quo[DIV_STAGES];

    // quotient of a ramp never passes 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_RAMP || out_kind == KIND_SRISE ||
                      out_kind == KIND_SFALL) |-> out_quo <= ONE_Q)
        else $error("pme_div: quotient above 1.0");

    // final remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_RAMP) |-> st_rem[DIV_STAGES] < {1'b0, st_den[DIV_STAGES]})
        else $error("pme_div: remainder not reduced");

    // a held beat is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_quo))
        else $error("pme_div: stalled beat lost");

endmodule

[rtl/pme_shape.sv]
// ----------------------------------------------------------------------------
// pme_shape
// Last two stages: squares the quotient for the s-curve, then forms the
// saturated degree and the ordering flag into the output register.
// ----------------------------------------------------------------------------
module pme_shape
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pme_pkg::kind_t                in_kind,
    input  logic [pme_pkg::QUO_W-1:0]     in_quo,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pme_pkg::DEG_W-1:0]     out_degree,
    output logic                          out_error
);
    import pme_pkg::*;

    logic              mul_valid_reg;
    kind_t             mul_kind_reg;
    logic [QUO_W-1:0]  mul_quo_reg;
    logic [PROD_W-1:0] mul_prod_reg;
    logic              mul_ready;

    logic              fin_valid_reg;
    logic [DEG_W-1:0]  fin_degree_reg;
    logic [DEG_W-1:0]  fin_degree_next;
    logic              fin_error_reg;
    logic              fin_error_next;
    logic              fin_ready;
    logic [SQ_W-1:0]   sq;

    // square stage
    assign fin_ready = !fin_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || fin_ready;
    assign in_ready  = mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (mul_ready)
            mul_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && in_valid)
        begin
            mul_kind_reg <= in_kind;
            mul_quo_reg  <= in_quo;
            mul_prod_reg <= PROD_W'(in_quo) * PROD_W'(in_quo);
        end
    end

    // 2*f*f >> FRAC_W is f*f >> (FRAC_W-1)
    assign sq = mul_prod_reg[FRAC_W-1 +: SQ_W];

    // degree select and saturation
    always_comb
    begin
        fin_degree_next = '0;
        fin_error_next  = 1'b0;
        case (mul_kind_reg)
            KIND_ZERO:  fin_degree_next = '0;
            KIND_ONE:   fin_degree_next = ONE_Q;
            KIND_ERR:   fin_error_next  = 1'b1;
            KIND_RAMP:  fin_degree_next = mul_quo_reg;
            KIND_SRISE: fin_degree_next = (sq > {1'b0, ONE_Q}) ? ONE_Q : sq[DEG_W-1:0];
            KIND_SFALL: fin_degree_next = (sq > {1'b0, ONE_Q}) ? '0 : (ONE_Q - sq[DEG_W-1:0]);
            default:    fin_degree_next = '0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (fin_ready)
            fin_valid_reg <= mul_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && mul_valid_reg)
        begin
            fin_degree_reg <= fin_degree_next;
            fin_error_reg  <= fin_error_next;
        end
    end

    assign out_valid  = fin_valid_reg;
    assign out_degree = fin_degree_reg;
    assign out_error  = fin_error_reg;

    // flagged ordering always gives zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_degree == '0)
        else $error("pme_shape: error beat with non-zero degree");

    // degree never passes 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_degree <= ONE_Q)
        else $error("pme_shape: degree above 1.0");

    // a full square stage behind a stalled output waits
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_valid_reg && out_valid && !out_ready |=> mul_valid_reg && $stable(mul_quo_reg))
        else $error("pme_shape: square stage overwritten during stall");

endmodule

[rtl/piecewise_membership_eval.sv]
// ----------------------------------------------------------------------------
// piecewise_membership_eval
// Fuzzy membership degree of a signed sample for a configurable shape:
// rising, triangle, falling, trapezoid or quadratic s-curve.
// ----------------------------------------------------------------------------
// Usage
//   s_tvalid/s_tready/s_tdata carry one sample per beat; m_tvalid/m_tready/
//   m_tdata return one degree per sample, in order.
//   cfg_wr_en/cfg_index/cfg_wdata write shape_mode (0) and the breakpoints
//   a..d (1..4); write only while the pipeline is empty.
// Pipeline: an accepted sample passes one compare stage, eight divider
//   stages, one square stage and one output register before its result
//   reaches m_tdata.
// Throughput: one sample per cycle while m_tready is high; the divider retires
//   two quotient bits per stage, so every stage can take a new beat each cycle.
// Reset: the pipeline empties and the registers return to trapezoid with
//   a=0, b=1, c=2, d=3.
// Stall: when m_tready is low, beats close up behind the output register
//   and the empty stages still take input; s_tready drops only when every
//   stage is full.
// ----------------------------------------------------------------------------
module piecewise_membership_eval
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [pme_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pme_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // sample stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [pme_pkg::S_TDATA_W-1:0]         s_tdata,   // [15:0] sample
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pme_pkg::M_TDATA_W-1:0]         m_tdata    // [15:0] degree, [16] order_error
);
    import pme_pkg::*;

    logic [MODE_W-1:0]          shape_mode_reg;
    logic signed [SAMPLE_W-1:0] point_a_reg;
    logic signed [SAMPLE_W-1:0] point_b_reg;
    logic signed [SAMPLE_W-1:0] point_c_reg;
    logic signed [SAMPLE_W-1:0] point_d_reg;

    logic              fr_valid;
    logic              fr_ready;
    kind_t             fr_kind;
    logic [DEN_W-1:0]  fr_num;
    logic [DEN_W-1:0]  fr_den;

    logic              dv_valid;
    logic              dv_ready;
    kind_t             dv_kind;
    logic [QUO_W-1:0]  dv_quo;

    logic [DEG_W-1:0]  degree;
    logic              order_error;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg <= MODE_TRAPEZOID;
            point_a_reg    <= SAMPLE_W'(0);
            point_b_reg    <= SAMPLE_W'(1);
            point_c_reg    <= SAMPLE_W'(2);
            point_d_reg    <= SAMPLE_W'(3);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SHAPE_MODE: shape_mode_reg <= cfg_wdata[MODE_W-1:0];
                REG_POINT_A:    point_a_reg    <= cfg_wdata[SAMPLE_W-1:0];
                REG_POINT_B:    point_b_reg    <= cfg_wdata[SAMPLE_W-1:0];
                REG_POINT_C:    point_c_reg    <= cfg_wdata[SAMPLE_W-1:0];
                REG_POINT_D:    point_d_reg    <= cfg_wdata[SAMPLE_W-1:0];
                default:        ;
            endcase
        end
    end

    // compare and operand stage
    pme_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .sample     (s_tdata[SAMPLE_W-1:0]),
        .shape_mode (shape_mode_reg),
        .point_a    (point_a_reg),
        .point_b    (point_b_reg),
        .point_c    (point_c_reg),
        .point_d    (point_d_reg),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_kind   (fr_kind),
        .out_num    (fr_num),
        .out_den    (fr_den)
    );

    // ramp divider
    pme_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (fr_valid),
        .in_ready   (fr_ready),
        .in_kind    (fr_kind),
        .in_num     (fr_num),
        .in_den     (fr_den),
        .out_valid  (dv_valid),
        .out_ready  (dv_ready),
        .out_kind   (dv_kind),
        .out_quo    (dv_quo)
    );

    // square, saturate, output register
    pme_shape u_shape
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dv_valid),
        .in_ready   (dv_ready),
        .in_kind    (dv_kind),
        .in_quo     (dv_quo),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_degree (degree),
        .out_error  (order_error)
    );

    // result beat packing
    assign m_tdata = {(M_TDATA_W - DEG_W - 1)'(0), order_error, degree};

endmodule
